// ----- src/cube_map_face_select_macros.svh -----
// assertion macros for the cube map face select block
`ifndef CUBE_MAP_FACE_SELECT_MACROS_SVH
`define CUBE_MAP_FACE_SELECT_MACROS_SVH
// property must hold on every clock edge outside reset
`define CMFS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// implication checked on every clock edge outside reset
`define CMFS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`endif

// ----- src/cmfs_pkg.sv -----
// shared types and constants for the cube map face select block
package cmfs_pkg;
	typedef enum logic [1:0] {
		OP_FACE = 2'd0,
		OP_S    = 2'd1,
		OP_T    = 2'd2,
		OP_MA   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		FACE_X = 2'd0,
		FACE_Y = 2'd1,
		FACE_Z = 2'd2
	} face_t;

	localparam logic [31:0] F_ZERO  = 32'h0000_0000;
	localparam logic [31:0] F_ONE   = 32'h3F80_0000;
	localparam logic [31:0] F_TWO   = 32'h4000_0000;
	localparam logic [31:0] F_THREE = 32'h4040_0000;
	localparam logic [31:0] F_FOUR  = 32'h4080_0000;
	localparam logic [31:0] F_FIVE  = 32'h40A0_0000;

	// classification of one component
	typedef struct packed {
		logic nan;
		logic neg;
	} cls_t;

	function automatic cls_t classify(input logic [31:0] v);
		cls_t c;
		c.nan = (v[30:0] > 31'h7F80_0000);
		c.neg = !c.nan && v[31] && (v[30:0] != 31'd0);
		return c;
	endfunction

	function automatic logic [31:0] times_two(input logic [31:0] v);
		logic [31:0] r;
		if (v[30:23] == 8'hFF) begin
			r = (v[22:0] != 23'd0) ? (v | 32'h0040_0000) : v;
		end else if (v[30:23] == 8'h00) begin
			// subnormal: the fraction shifts up and may carry into the exponent
			r = {v[31], 7'd0, v[22:0], 1'b0};
		end else if (v[30:23] == 8'hFE) begin
			r = {v[31], 8'hFF, 23'd0};
		end else begin
			r = {v[31], v[30:23] + 8'd1, v[22:0]};
		end
		return r;
	endfunction
endpackage

// ----- src/cmfs_classify.sv -----
// stage one: component classification and magnitude compares
module cmfs_classify (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        vin,
	input  logic [1:0]  opcode,
	input  logic [31:0] x_value,
	input  logic [31:0] y_value,
	input  logic [31:0] z_value,
	output logic        v_s1,
	output logic [1:0]  op_s1,
	output logic [31:0] x_s1,
	output logic [31:0] y_s1,
	output logic [31:0] z_s1,
	output cmfs_pkg::cls_t xc_s1,
	output cmfs_pkg::cls_t yc_s1,
	output cmfs_pkg::cls_t zc_s1,
	output logic        zx_s1,
	output logic        zy_s1,
	output logic        yx_s1
);
	cmfs_pkg::cls_t xc, yc, zc;
	always_comb begin
		xc = cmfs_pkg::classify(x_value);
		yc = cmfs_pkg::classify(y_value);
		zc = cmfs_pkg::classify(z_value);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= opcode;
			x_s1  <= x_value;
			y_s1  <= y_value;
			z_s1  <= z_value;
			xc_s1 <= xc;
			yc_s1 <= yc;
			zc_s1 <= zc;
			zx_s1 <= !zc.nan && !xc.nan && (z_value[30:0] >= x_value[30:0]);
			zy_s1 <= !zc.nan && !yc.nan && (z_value[30:0] >= y_value[30:0]);
			yx_s1 <= !yc.nan && !xc.nan && (y_value[30:0] >= x_value[30:0]);
		end
	end
endmodule

// ----- src/cmfs_select.sv -----
// stages two and three: face decision, then result selection
module cmfs_select (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        v_s1,
	input  logic [1:0]  op_s1,
	input  logic [31:0] x_s1,
	input  logic [31:0] y_s1,
	input  logic [31:0] z_s1,
	input  cmfs_pkg::cls_t xc_s1,
	input  cmfs_pkg::cls_t yc_s1,
	input  cmfs_pkg::cls_t zc_s1,
	input  logic        zx_s1,
	input  logic        zy_s1,
	input  logic        yx_s1,
	output logic        v_s3,
	output logic [31:0] r_s3
);
	logic              v_s2;
	cmfs_pkg::op_t     op_s2;
	cmfs_pkg::face_t   face_s2;
	logic              neg_s2;
	logic [31:0]       maj_s2;
	logic [31:0]       sc_s2;
	logic [31:0]       tc_s2;
	cmfs_pkg::face_t   face;
	logic [31:0]       r;

	always_comb begin
		if (zx_s1 && zy_s1) face = cmfs_pkg::FACE_Z;
		else if (yx_s1)     face = cmfs_pkg::FACE_Y;
		else                face = cmfs_pkg::FACE_X;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2   <= cmfs_pkg::op_t'(op_s1);
			face_s2 <= face;
			unique case (face)
				cmfs_pkg::FACE_X: begin
					neg_s2 <= xc_s1.neg;
					maj_s2 <= x_s1;
					sc_s2  <= xc_s1.neg ? z_s1 : {~z_s1[31], z_s1[30:0]};
					tc_s2  <= {~y_s1[31], y_s1[30:0]};
				end
				cmfs_pkg::FACE_Y: begin
					neg_s2 <= yc_s1.neg;
					maj_s2 <= y_s1;
					sc_s2  <= x_s1;
					tc_s2  <= yc_s1.neg ? {~z_s1[31], z_s1[30:0]} : z_s1;
				end
				default: begin
					neg_s2 <= zc_s1.neg;
					maj_s2 <= z_s1;
					sc_s2  <= zc_s1.neg ? {~x_s1[31], x_s1[30:0]} : x_s1;
					tc_s2  <= {~y_s1[31], y_s1[30:0]};
				end
			endcase
			r_s3 <= r;
		end
	end

	always_comb begin
		unique case (op_s2)
			cmfs_pkg::OP_FACE: begin
				unique case (face_s2)
					cmfs_pkg::FACE_X: r = neg_s2 ? cmfs_pkg::F_ONE : cmfs_pkg::F_ZERO;
					cmfs_pkg::FACE_Y: r = neg_s2 ? cmfs_pkg::F_THREE : cmfs_pkg::F_TWO;
					default:          r = neg_s2 ? cmfs_pkg::F_FIVE : cmfs_pkg::F_FOUR;
				endcase
			end
			cmfs_pkg::OP_S: r = sc_s2;
			cmfs_pkg::OP_T: r = tc_s2;
			default:        r = cmfs_pkg::times_two(maj_s2);
		endcase
	end
endmodule

// ----- src/cube_map_face_select.sv -----
// cube map face select top level: three-stage pipeline with a global stall
// a request is registered in stage one, then stage two, then stage three, whose register drives the result
// throughput: one request per cycle while the output is not stalled, every stage takes a new request each such cycle
// a stalled output freezes every stage, bubbles included
// reset clears all stage valid bits; payload registers are not reset
`include "cube_map_face_select_macros.svh"
module cube_map_face_select (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [31:0] x_value,
	input  logic [31:0] y_value,
	input  logic [31:0] z_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] result_bits
);
	logic           en;
	logic           v_s1;
	logic [1:0]     op_s1;
	logic [31:0]    x_s1, y_s1, z_s1;
	cmfs_pkg::cls_t xc_s1, yc_s1, zc_s1;
	logic           zx_s1, zy_s1, yx_s1;

	assign en       = out_ready || !out_valid;
	assign in_ready = en;

	cmfs_classify u_cls (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(in_valid),
		.opcode(opcode), .x_value(x_value), .y_value(y_value), .z_value(z_value),
		.v_s1(v_s1), .op_s1(op_s1), .x_s1(x_s1), .y_s1(y_s1), .z_s1(z_s1),
		.xc_s1(xc_s1), .yc_s1(yc_s1), .zc_s1(zc_s1),
		.zx_s1(zx_s1), .zy_s1(zy_s1), .yx_s1(yx_s1)
	);

	cmfs_select u_sel (
		.clk(clk), .arst_n(arst_n), .en(en), .v_s1(v_s1), .op_s1(op_s1),
		.x_s1(x_s1), .y_s1(y_s1), .z_s1(z_s1),
		.xc_s1(xc_s1), .yc_s1(yc_s1), .zc_s1(zc_s1),
		.zx_s1(zx_s1), .zy_s1(zy_s1), .yx_s1(yx_s1),
		.v_s3(out_valid), .r_s3(result_bits)
	);

	`CMFS_ASSERT(a_stall_holds, (out_valid && !out_ready) |=> (out_valid && $stable(result_bits)), "stalled result changed")
	`CMFS_ASSERT_IMP(a_ready_free, !out_valid, in_ready, "input blocked with empty output")
	`CMFS_ASSERT(a_nan_no_neg, !(xc_s1.nan && xc_s1.neg), "nan classed negative")
endmodule
